FILE: hdl/dtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared widths, codes and types for the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam int NumTimersDefault = 16;
   localparam int OpWidth    = 2;
   localparam int IdWidth    = 4;
   localparam int TimeWidth  = 64;
   localparam int KindWidth  = 3;

   localparam logic [OpWidth-1:0] OP_INSTALL = 2'd0;
   localparam logic [OpWidth-1:0] OP_CANCEL  = 2'd1;
   localparam logic [OpWidth-1:0] OP_SERVICE = 2'd2;
   localparam logic [OpWidth-1:0] OP_UNUSED  = 2'd3;

   localparam logic [KindWidth-1:0] K_INSTALLED = 3'd0;
   localparam logic [KindWidth-1:0] K_BUSY      = 3'd1;
   localparam logic [KindWidth-1:0] K_CANCELED  = 3'd2;
   localparam logic [KindWidth-1:0] K_NOOP      = 3'd3;
   localparam logic [KindWidth-1:0] K_FIRED     = 3'd4;
   localparam logic [KindWidth-1:0] K_ARM       = 3'd5;
   localparam logic [KindWidth-1:0] K_IDLE      = 3'd6;

   localparam logic [1:0] ST_UNUSED   = 2'd0;
   localparam logic [1:0] ST_QUEUED   = 2'd1;
   localparam logic [1:0] ST_CANCELED = 2'd2;
   localparam logic [1:0] ST_FIRED    = 2'd3;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic                 insert;  // place new entry
      logic                 remove;  // drop entry matching id
      logic                 pop;     // shift everything toward the head
      logic [IdWidth-1:0]   id;
      logic [TimeWidth-1:0] dl;
   } cell_cmd_type;

   // an entry as held in, and passed between, cells
   typedef struct packed {
      logic                 vld;
      logic [IdWidth-1:0]   id;
      logic [TimeWidth-1:0] dl;
   } entry_type;

endpackage

FILE: hdl/dtq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_req_if / dtq_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface dtq_req_if import dtq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OpWidth-1:0]   opcode;
   logic [IdWidth-1:0]   timer_id;
   logic [TimeWidth-1:0] delta_ns;
   logic [TimeWidth-1:0] now_ns;
   modport source (output valid, opcode, timer_id, delta_ns, now_ns, input ready);
   modport sink   (input valid, opcode, timer_id, delta_ns, now_ns, output ready);
endinterface

interface dtq_rsp_if import dtq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KindWidth-1:0] kind;
   logic [IdWidth-1:0]   slot;
   logic [TimeWidth-1:0] when_ns;
   logic                 last;
   modport source (output valid, kind, slot, when_ns, last, input ready);
   modport sink   (input valid, kind, slot, when_ns, last, output ready);
endinterface

FILE: hdl/dtq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_cell
// One position of the sorted queue; talks only to its two neighbors.
// ----------------------------------------------------------------------------
module dtq_cell
   import dtq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  entry_type    prev_entry,  // neighbor toward the head
   input  logic         prev_shift,  // neighbor shifts down (remove below us)
   input  logic         prev_new,    // neighbor sits before new entry
   input  entry_type    next_entry,  // neighbor toward the tail
   output entry_type    cur_entry,
   output logic         shift_out,
   output logic         new_out
);

   entry_type entry_ff, entry_in;
   logic      before_new;

   // entry precedes the new one: earlier deadline, or tie with lower slot
   assign before_new = entry_ff.vld &&
      ((entry_ff.dl < cmd.dl) || ((entry_ff.dl == cmd.dl) && (entry_ff.id < cmd.id)));
   assign new_out   = before_new;
   assign shift_out = prev_shift || (entry_ff.vld && entry_ff.id == cmd.id);
   assign cur_entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (!before_new) begin
            if (prev_new) begin
               entry_in.vld = 1'b1;
               entry_in.id  = cmd.id;
               entry_in.dl  = cmd.dl;
            end else begin
               entry_in = prev_entry;
            end
         end
      end else if (cmd.pop) begin
         entry_in = next_entry;
      end else if (cmd.remove && shift_out) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.vld <= 1'b0;
      end else begin
         entry_ff.vld <= entry_in.vld;
      end
      entry_ff.id <= entry_in.id;
      entry_ff.dl <= entry_in.dl;
   end

endmodule

FILE: hdl/deadline_timer_queue_top.sv
`timescale 1ns / 1ps
// An install or cancel word is presented the cycle after the request is taken;
// a service request goes to the service state first, which registers its first word.
// One request at a time; service answers with its fired words, then a last word;
// one fired word per cycle while the receiver keeps up, as the head cell pops and
// the chain advances; a stall holds it. The single output register sets the pace.
// Reset: synchronous; empties the queue and marks every slot unused.
// ----------------------------------------------------------------------------
// deadline_timer_queue_top
// Timer slots kept in deadline order by a chain of sort cells.
// ----------------------------------------------------------------------------
module deadline_timer_queue_top
   import dtq_pkg::*;
#(
   parameter int NUM_TIMERS = NumTimersDefault
)(
   input  logic       clock,
   input  logic       reset,
   dtq_req_if.sink    req,
   dtq_rsp_if.source  rsp
);

   localparam int IdxWidth = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SERV = 2'd1;

   logic [1:0] state_ff, state_in;
   logic [1:0] status_ff [NUM_TIMERS];
   logic [TimeWidth-1:0] now_ff;

   // output register
   logic                 ovld_ff;
   logic [KindWidth-1:0] okind_ff;
   logic [IdWidth-1:0]   oslot_ff;
   logic [TimeWidth-1:0] owhen_ff;
   logic                 olast_ff;

   cell_cmd_type cmd;
   entry_type    ent   [NUM_TIMERS];
   logic         shf   [NUM_TIMERS];
   logic         nw    [NUM_TIMERS];

   logic                 accept, in_range, queued;
   logic [IdxWidth-1:0]  req_idx, head_idx;
   logic [TimeWidth:0]   sum;
   logic [TimeWidth-1:0] dl;
   logic                 out_free;

   assign out_free  = !ovld_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req.valid && req.ready;
   assign in_range  = int'(req.timer_id) < NUM_TIMERS;
   assign req_idx   = IdxWidth'(req.timer_id);
   assign head_idx  = IdxWidth'(ent[0].id);
   assign queued    = in_range && status_ff[req_idx] == ST_QUEUED;
   assign sum = {1'b0, req.now_ns} + {1'b0, req.delta_ns};
   assign dl  = sum[TimeWidth] ? {TimeWidth{1'b1}} : sum[TimeWidth-1:0];

   // broadcast command
   always_comb begin
      cmd        = '0;
      cmd.id     = req.timer_id;
      cmd.dl     = dl;
      if (accept && req.opcode == OP_INSTALL && in_range && !queued) cmd.insert = 1'b1;
      if (accept && req.opcode == OP_CANCEL && queued) cmd.remove = 1'b1;
      if (state_ff == S_SERV && out_free && ent[0].vld && ent[0].dl <= now_ff)
         cmd.pop = 1'b1;
   end

   // build the chain
   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
      entry_type pe, ne;
      logic      ps, pn;
      if (g == 0) begin : g_head
         assign pe = '0;
         assign ps = 1'b0;
         assign pn = 1'b1;
      end else begin : g_body
         assign pe = ent[g-1];
         assign ps = shf[g-1];
         assign pn = nw[g-1];
      end
      if (g == NUM_TIMERS-1) begin : g_tail
         assign ne = '0;
      end else begin : g_mid
         assign ne = ent[g+1];
      end
      dtq_cell u_cell (
         .clock, .reset, .cmd,
         .prev_entry(pe), .prev_shift(ps), .prev_new(pn), .next_entry(ne),
         .cur_entry(ent[g]), .shift_out(shf[g]), .new_out(nw[g])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept && req.opcode == OP_SERVICE) state_in = S_SERV;
         S_SERV:  if (out_free && !cmd.pop) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ovld_ff  <= 1'b0;
         for (int i = 0; i < NUM_TIMERS; i++) status_ff[i] <= ST_UNUSED;
      end else begin
         state_ff <= state_in;
         if (accept) now_ff <= req.now_ns;
         if (accept && (req.opcode == OP_INSTALL || req.opcode == OP_CANCEL)) begin
            // answer install or cancel with a single word
            ovld_ff  <= 1'b1;
            olast_ff <= 1'b1;
            oslot_ff <= req.timer_id;
            if (req.opcode == OP_INSTALL) begin
               if (cmd.insert) begin
                  okind_ff <= K_INSTALLED;
                  owhen_ff <= dl;
                  status_ff[req_idx] <= ST_QUEUED;
               end else begin
                  okind_ff <= K_BUSY;
                  owhen_ff <= '0;
               end
            end else begin
               owhen_ff <= '0;
               if (cmd.remove) begin
                  okind_ff <= K_CANCELED;
                  status_ff[req_idx] <= ST_CANCELED;
               end else begin
                  okind_ff <= K_NOOP;
               end
            end
         end else if (state_ff == S_SERV && out_free) begin
            ovld_ff <= 1'b1;
            if (cmd.pop) begin
               // fire the head and advance the chain
               okind_ff <= K_FIRED;
               oslot_ff <= ent[0].id;
               owhen_ff <= ent[0].dl;
               olast_ff <= 1'b0;
               status_ff[head_idx] <= ST_FIRED;
            end else begin
               okind_ff <= ent[0].vld ? K_ARM : K_IDLE;
               oslot_ff <= '0;
               owhen_ff <= ent[0].vld ? ent[0].dl : '0;
               olast_ff <= 1'b1;
            end
         end else if (rsp.ready) begin
            // word taken, nothing new to present
            ovld_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid   = ovld_ff;
   assign rsp.kind    = okind_ff;
   assign rsp.slot    = oslot_ff;
   assign rsp.when_ns = owhen_ff;
   assign rsp.last    = olast_ff;

   // no new word while a service burst runs
   a_no_accept_in_serv: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SERV |-> !accept) else $error("accept during service");
   // head never fires past now
   a_pop_expired: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> ent[0].dl <= now_ff) else $error("early fire");
   // chain stays packed
   a_packed: assert property (@(posedge clock) disable iff (reset)
      !ent[0].vld |-> !ent[NUM_TIMERS-1].vld || NUM_TIMERS == 1) else $error("gap");

endmodule

FILE: sim/deadline_timer_queue_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_queue_top_test
// Drives install, cancel and service words into the timer queue and checks
// every response word against an in-bench deadline queue model, under
// several sender and receiver idle mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module deadline_timer_queue_top_test;
   import dtq_pkg::*;

   localparam int NT = NumTimersDefault;
   localparam logic [TimeWidth-1:0] TMAX = '1;
   localparam int CycleLimit = 400000;

   typedef struct packed {
      logic [OpWidth-1:0]   opcode;
      logic [IdWidth-1:0]   timer_id;
      logic [TimeWidth-1:0] delta_ns;
      logic [TimeWidth-1:0] now_ns;
   } req_word_type;

   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic [IdWidth-1:0]   slot;
      logic [TimeWidth-1:0] when_ns;
      logic                 last;
   } rsp_word_type;

   // a directed row: the request, and optionally the single response it gives
   typedef struct packed {
      req_word_type word;
      logic         typed;
      rsp_word_type rsp;
   } row_type;

   logic clock;
   logic reset;
   dtq_req_if req ();
   dtq_rsp_if rsp ();

   deadline_timer_queue_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // timer queue model state
   logic [TimeWidth-1:0] tq_deadline [NT];
   logic [1:0]           tq_status   [NT];
   logic [IdWidth-1:0]   tq_order[$];

   rsp_word_type pending_rsp[$];

   int  fail_count;
   int  cycle_count;
   int  send_idle_pct;
   int  recv_stall_pct;
   int  hold_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // guard against a hung block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic precedes(logic [IdWidth-1:0] a, logic [IdWidth-1:0] b);
      if (tq_deadline[a] != tq_deadline[b]) return tq_deadline[a] < tq_deadline[b];
      return a < b;
   endfunction

   // advance the model by one request word and queue the responses it gives
   task automatic predict_timer_rsp(input req_word_type w);
      rsp_word_type r;
      logic [TimeWidth:0] sum;
      logic [IdWidth-1:0] s;
      int pos;
      r = '0;
      r.slot = w.timer_id;
      r.last = 1'b1;
      case (w.opcode)
         OP_INSTALL: begin
            if (tq_status[w.timer_id] == ST_QUEUED) begin
               r.kind = K_BUSY;
            end else begin
               sum = {1'b0, w.now_ns} + {1'b0, w.delta_ns};
               tq_deadline[w.timer_id] = sum[TimeWidth] ? TMAX : sum[TimeWidth-1:0];
               tq_status[w.timer_id] = ST_QUEUED;
               pos = tq_order.size();
               while (pos > 0 && precedes(w.timer_id, tq_order[pos-1])) pos--;
               tq_order.insert(pos, w.timer_id);
               r.kind = K_INSTALLED;
               r.when_ns = tq_deadline[w.timer_id];
            end
            pending_rsp.push_back(r);
         end
         OP_CANCEL: begin
            if (tq_status[w.timer_id] != ST_QUEUED) begin
               r.kind = K_NOOP;
            end else begin
               foreach (tq_order[i]) if (tq_order[i] == w.timer_id) begin
                  tq_order.delete(i);
                  break;
               end
               tq_status[w.timer_id] = ST_CANCELED;
               r.kind = K_CANCELED;
            end
            pending_rsp.push_back(r);
         end
         OP_SERVICE: begin
            // pop everything due, then arm on the new head or go idle
            while (tq_order.size() > 0 && tq_deadline[tq_order[0]] <= w.now_ns) begin
               s = tq_order.pop_front();
               tq_status[s] = ST_FIRED;
               r = '0;
               r.kind = K_FIRED;
               r.slot = s;
               r.when_ns = tq_deadline[s];
               pending_rsp.push_back(r);
            end
            r = '0;
            r.last = 1'b1;
            if (tq_order.size() > 0) begin
               r.kind = K_ARM;
               r.when_ns = tq_deadline[tq_order[0]];
            end else begin
               r.kind = K_IDLE;
            end
            pending_rsp.push_back(r);
         end
         default: ;
      endcase
   endtask

   // hold one word on the request channel until it is taken; call at a falling edge
   task automatic send_word(input req_word_type w);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid    = 1'b1;
      req.opcode   = w.opcode;
      req.timer_id = w.timer_id;
      req.delta_ns = w.delta_ns;
      req.now_ns   = w.now_ns;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_timer_rsp(w);
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   // receiver: stall at random, and drain a long hold-off when one is asked
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   // compare each accepted response word with the oldest expectation
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response word kind=%0d slot=%0d", rsp.kind, rsp.slot);
            fail_count++;
         end else begin
            exp_w = pending_rsp.pop_front();
            if (rsp.kind !== exp_w.kind) begin
               $error("kind: expected %0d, got %0d", exp_w.kind, rsp.kind);
               fail_count++;
            end
            if (rsp.slot !== exp_w.slot) begin
               $error("slot: expected %0d, got %0d", exp_w.slot, rsp.slot);
               fail_count++;
            end
            if (rsp.when_ns !== exp_w.when_ns) begin
               $error("when_ns: expected %0h, got %0h", exp_w.when_ns, rsp.when_ns);
               fail_count++;
            end
            if (rsp.last !== exp_w.last) begin
               $error("last: expected %0d, got %0d", exp_w.last, rsp.last);
               fail_count++;
            end
         end
      end
   end

   function automatic logic [TimeWidth-1:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic req_word_type mk(logic [OpWidth-1:0] op, int id,
                                       logic [TimeWidth-1:0] d, logic [TimeWidth-1:0] n);
      req_word_type w;
      w.opcode = op;
      w.timer_id = IdWidth'(id);
      w.delta_ns = d;
      w.now_ns = n;
      return w;
   endfunction

   function automatic rsp_word_type rw(logic [KindWidth-1:0] k, int s,
                                       logic [TimeWidth-1:0] t);
      rsp_word_type r;
      r.kind = k;
      r.slot = IdWidth'(s);
      r.when_ns = t;
      r.last = 1'b1;
      return r;
   endfunction

   // random traffic; time mostly moves forward so deadlines fire in bursts
   task automatic run_random(input int count);
      logic [TimeWidth-1:0] clk_now;
      req_word_type w;
      int pick;
      clk_now = rand64() >> $urandom_range(40, 1);
      repeat (count) begin
         pick = $urandom_range(99);
         w = mk(OP_INSTALL, $urandom_range(NT-1), 0, clk_now);
         if (pick < 50) begin
            w.opcode = OP_INSTALL;
            case ($urandom_range(9))
               0: w.delta_ns = rand64();
               1: w.delta_ns = TMAX - TimeWidth'($urandom_range(3));
               2: w.delta_ns = 0;
               default: w.delta_ns = TimeWidth'($urandom_range(2000));
            endcase
         end else if (pick < 68) begin
            w.opcode = OP_CANCEL;
         end else if (pick < 96) begin
            w.opcode = OP_SERVICE;
            clk_now += TimeWidth'($urandom_range(1500));
            if ($urandom_range(19) == 0) clk_now = rand64();
            w.now_ns = clk_now;
         end else begin
            w.opcode = OP_UNUSED;  // no response
            w.delta_ns = rand64();
            w.now_ns = rand64();
         end
         if ($urandom_range(9) == 0) w.now_ns = rand64();
         send_word(w);
      end
   endtask

   // wait for every expected word, then return at a falling edge
   task automatic wait_drain();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   row_type dir_rows[$];

   initial begin
      fail_count     = 0;
      cycle_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_cycles    = 0;
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.opcode     = OP_INSTALL;
      req.timer_id   = '0;
      req.delta_ns   = '0;
      req.now_ns     = '0;
      rsp.ready      = 1'b0;
      foreach (tq_status[i]) begin
         tq_status[i] = ST_UNUSED;
         tq_deadline[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows; typed responses are the ones obvious at a glance
      dir_rows = '{
         '{mk(OP_SERVICE, 0, 0, 0),          1'b1, rw(K_IDLE, 0, 0)},
         '{mk(OP_CANCEL, 3, 0, 0),           1'b1, rw(K_NOOP, 3, 0)},
         '{mk(OP_INSTALL, 0, 100, 50),       1'b1, rw(K_INSTALLED, 0, 150)},
         '{mk(OP_INSTALL, 0, 5, 5),          1'b1, rw(K_BUSY, 0, 0)},
         '{mk(OP_INSTALL, 15, TMAX, TMAX),   1'b1, rw(K_INSTALLED, 15, TMAX)},
         '{mk(OP_INSTALL, 7, TMAX, 0),       1'b1, rw(K_INSTALLED, 7, TMAX)},
         '{mk(OP_INSTALL, 9, 150, 0),        1'b1, rw(K_INSTALLED, 9, 150)},
         '{mk(OP_INSTALL, 4, 150, 0),        1'b1, rw(K_INSTALLED, 4, 150)},
         '{mk(OP_INSTALL, 2, 0, 0),          1'b1, rw(K_INSTALLED, 2, 0)},
         '{mk(OP_INSTALL, 5, 1000, 0),       1'b1, rw(K_INSTALLED, 5, 1000)},
         '{mk(OP_CANCEL, 5, 0, 0),           1'b1, rw(K_CANCELED, 5, 0)},
         '{mk(OP_CANCEL, 5, 0, 0),           1'b1, rw(K_NOOP, 5, 0)},
         '{mk(OP_UNUSED, 1, TMAX, TMAX),     1'b0, '0},
         '{mk(OP_SERVICE, 0, 0, 149),        1'b0, '0},
         '{mk(OP_SERVICE, 0, TMAX, 150),     1'b0, '0},
         '{mk(OP_CANCEL, 4, 0, 0),           1'b1, rw(K_NOOP, 4, 0)},
         '{mk(OP_INSTALL, 4, 1, TMAX - 1),   1'b1, rw(K_INSTALLED, 4, TMAX)},
         '{mk(OP_SERVICE, 0, 0, TMAX - 1),   1'b0, '0},
         '{mk(OP_SERVICE, 0, 0, TMAX),       1'b0, '0},
         '{mk(OP_SERVICE, 0, 0, TMAX),       1'b1, rw(K_IDLE, 0, 0)},
         '{mk(OP_CANCEL, 15, TMAX, TMAX),    1'b1, rw(K_NOOP, 15, 0)}
      };
      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].word);
         if (dir_rows[i].typed) begin
            if (pending_rsp.size() == 0) begin
               $error("directed row %0d: no response expected by the model", i);
               fail_count++;
            end else if (pending_rsp[pending_rsp.size()-1] !== dir_rows[i].rsp) begin
               $error("directed row %0d: model disagrees with typed response", i);
               fail_count++;
            end
         end
      end
      wait_drain();

      // idle mixes: none, sender, receiver, both
      run_random(22);
      send_idle_pct = 53;
      run_random(22);
      send_idle_pct = 0;
      recv_stall_pct = 53;
      run_random(22);
      send_idle_pct = 35;
      recv_stall_pct = 35;
      run_random(22);
      send_idle_pct = 0;
      recv_stall_pct = 0;

      // long receiver hold-off while requests keep coming, to back up the block
      @(posedge clock);
      hold_cycles = 300;
      @(negedge clock);
      run_random(12);

      wait_drain();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
